// ===== rtl/header_length_checksum_deframer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the header/length/checksum deframer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_UNIT_ASSERT_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check gated off while reset is asserted.
`define HLCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds through reset.
`define HLCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HLCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/hlcd_pkg.sv =====
// ---------------------------------------------------------------------------
// Deframer package
// Marker bytes, result codes and the result record shared by the RTL.
// ---------------------------------------------------------------------------
`default_nettype none

package hlcd_pkg;

  localparam logic [7:0] SyncByte    = 8'hA5;  // header marker
  localparam logic [7:0] ResyncByte  = 8'h5A;  // after SyncByte: restart frame
  localparam logic [7:0] FailCode    = 8'hFF;  // command code of a bad frame
  localparam logic [7:0] MinFrameLen = 8'd3;

  typedef struct packed {
    logic       emit;  // this beat ends a frame
    logic       good;  // checksum matched
    logic [7:0] code;  // command byte or FailCode
  } hlcd_result_t;

endpackage

`default_nettype wire

// ===== rtl/hlcd_frame_track.sv =====
// ---------------------------------------------------------------------------
// Deframer frame tracker
// Per-byte state update (position, length, command, sums) and verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module hlcd_frame_track #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [7:0]            byte_i,
  output hlcd_pkg::hlcd_result_t     result_o
);
  import hlcd_pkg::*;

  localparam int PosW = $clog2(BUFFER_DEPTH);

  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_q, hdr_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      rcv_q, rcv_d;

  logic [7:0] pos8;
  logic [7:0] pos_inc;
  logic [PosW-1:0] pos_sat;
  logic       is_sync;
  logic       is_resync_raw;
  logic       restart;
  logic [7:0] len_new, cmd_new, sum_base, sum_new, rcv_new;
  logic       good;

  always_comb begin
    pos8          = 8'(pos_q);
    pos_inc       = pos8 + 8'd1;
    pos_sat       = (pos_inc >= 8'(BUFFER_DEPTH)) ? PosW'(BUFFER_DEPTH - 1)
                                                  : PosW'(pos_inc);
    is_sync       = (byte_i == SyncByte);
    is_resync_raw = (byte_i == ResyncByte);
    restart       = is_resync_raw && hdr_q;

    // slot 0 carries the length and restarts the running sum
    len_new  = (pos8 == 8'd0) ? byte_i : len_q;
    sum_base = (pos8 == 8'd0) ? 8'd0 : sum_q;
    sum_new  = (({1'b0, pos8} + 9'd3) <= {1'b0, len_new}) ? sum_base + byte_i
                                                           : sum_base;
    rcv_new  = (({1'b0, pos8} + 9'd2) == {1'b0, len_new}) ? byte_i : rcv_q;
    cmd_new  = (pos8 == 8'd1) ? byte_i : cmd_q;

    good = (len_new >= MinFrameLen) && (sum_new == rcv_new);

    result_o.emit = !is_sync && !is_resync_raw && (pos_inc == len_new);
    result_o.good = good;
    result_o.code = good ? cmd_new : FailCode;

    hdr_d = is_sync;
    if (restart) begin
      pos_d = '0;
      len_d = len_q;
      cmd_d = cmd_q;
      sum_d = sum_q;
      rcv_d = rcv_q;
    end else begin
      pos_d = pos_sat;
      len_d = len_new;
      cmd_d = cmd_new;
      sum_d = sum_new;
      rcv_d = rcv_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= 1'b0;
      len_q <= '0;
      cmd_q <= '0;
      sum_q <= '0;
      rcv_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      hdr_q <= hdr_d;
      len_q <= len_d;
      cmd_q <= cmd_d;
      sum_q <= sum_d;
      rcv_q <= rcv_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/header_length_checksum_deframer_unit.sv =====
// Header/length/checksum deframer.
// Input channel: one received byte per beat on rx_byte_i (in_valid_i / in_stall_o).
// A 0xA5 0x5A pair restarts a frame; byte 0 of a frame is its length L,
// byte 1 its command, byte L-2 its checksum over bytes 0..L-3 (sum mod 256).
// Output channel: one beat per completed frame (out_valid_o / out_stall_i)
// carrying command_code_o (0xFF on failure) and checksum_good_o.
// Bytes that do not end a frame produce no output beat.
// Path: a byte waits in the input register; its frame result is registered
// into the output register as the byte leaves the input register.
// Throughput: one byte per cycle unless stalled; the tracker updates all state
// in the same cycle the byte leaves the input register.
// Stall: when the output register holds an untaken result and the byte in
// the input register would end a frame, that byte waits and in_stall_o rises;
// bytes that end no frame keep flowing past a stalled output.
// Reset: asynchronous, active low; clears the valid flags of both registers
// and all frame state (position 0, length 0, sums 0, no header seen).
// ---------------------------------------------------------------------------
// Deframer top level
// Input register, frame tracker and output result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "header_length_checksum_deframer_unit_assert.svh"

module header_length_checksum_deframer_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      command_code_o,
  output logic            checksum_good_o
);
  import hlcd_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_code_q;
  logic       out_good_q;

  hlcd_result_t res;
  logic         s1_adv;
  logic         step;
  logic         in_acc;
  logic         out_take;
  logic         emit_fire;

  hlcd_frame_track #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte_q),
    .result_o (res)
  );

  always_comb begin
    out_take    = out_valid_q && !out_stall_i;
    // only a frame-ending beat has to wait for the output register
    s1_adv      = !(res.emit && out_valid_q && out_stall_i);
    step        = s1_valid_q && s1_adv;
    emit_fire   = step && res.emit;
    in_stall_o  = s1_valid_q && !s1_adv;
    in_acc      = in_valid_i && !in_stall_o;
    s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
    out_valid_d = emit_fire || (out_valid_q && !out_take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
    end
    if (emit_fire) begin
      out_code_q <= res.code;
      out_good_q <= res.good;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_code_o  = out_code_q;
  assign checksum_good_o = out_good_q;

  `HLCD_ASSERT(a_stall_needs_byte, clk_i, rst_ni, in_stall_o |-> s1_valid_q, "stall without held byte")
  `HLCD_ASSERT(a_held_byte_stays, clk_i, rst_ni, (s1_valid_q && !s1_adv) |=> s1_valid_q, "held byte lost")
  `HLCD_ASSERT(a_no_overwrite, clk_i, rst_ni, emit_fire |-> !(out_valid_q && out_stall_i), "result overwritten")
  `HLCD_ASSERT(a_fail_code, clk_i, rst_ni, (out_valid_q && !out_good_q) |-> (out_code_q == FailCode), "bad frame code")
  `HLCD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!out_valid_q && !s1_valid_q), "not empty after reset")

endmodule

`default_nettype wire

// ===== dv/tb_header_length_checksum_deframer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer testbench
// Drives byte streams of sync-framed packets into the deframer and checks
// every frame verdict against a cycle-free software tracker of the framing.
// ---------------------------------------------------------------------------
module tb_header_length_checksum_deframer_unit;
  import hlcd_pkg::*;

  localparam int DEPTH          = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] command_code_o;
  logic       checksum_good_o;

  header_length_checksum_deframer_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_code_o (command_code_o),
    .checksum_good_o(checksum_good_o)
  );

  // Frame tracker state
  logic [7:0] wr_pos;
  logic       hdr_armed;
  logic [7:0] frame_len;
  logic [7:0] cmd_byte;
  logic [7:0] sum_acc;
  logic [7:0] sum_rcvd;

  hlcd_result_t pending_frames[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_start    = 1'b0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int frames_seen   = 0;
  int good_frames   = 0;
  int mismatches    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void store_byte(input logic [7:0] b);
    if (wr_pos == 8'd0) begin
      frame_len = b;
      sum_acc   = 8'd0;
    end
    if (wr_pos == 8'd1) cmd_byte = b;
    if (int'(wr_pos) + 3 <= int'(frame_len)) sum_acc = sum_acc + b;
    if (int'(wr_pos) + 2 == int'(frame_len)) sum_rcvd = b;
    wr_pos = wr_pos + 8'd1;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    hlcd_result_t r;
    r = '0;
    if (b == SyncByte) begin
      hdr_armed = 1'b1;
      store_byte(b);
    end else if (b == ResyncByte) begin
      if (hdr_armed) wr_pos = 8'd0;
      else store_byte(b);
      hdr_armed = 1'b0;
    end else begin
      store_byte(b);
      hdr_armed = 1'b0;
      r.emit = (wr_pos == frame_len);
    end
    if (r.emit) begin
      r.good = (frame_len >= MinFrameLen) && (sum_acc == sum_rcvd);
      r.code = r.good ? cmd_byte : FailCode;
      pending_frames.push_back(r);
    end
    if (int'(wr_pos) >= DEPTH) wr_pos = 8'(DEPTH - 1);
  endfunction

  // Input beats feed the tracker; output beats are checked against it.
  always @(posedge clk_i) begin
    hlcd_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        frames_seen++;
        if (pending_frames.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected frame result: expected none, got code %02h good %0b",
                   $time, command_code_o, checksum_good_o);
        end else begin
          exp_r = pending_frames.pop_front();
          if (exp_r.good) good_frames++;
          if (command_code_o !== exp_r.code) begin
            mismatches++;
            $display("%0t: command_code mismatch: expected %02h, got %02h",
                     $time, exp_r.code, command_code_o);
          end
          if (checksum_good_o !== exp_r.good) begin
            mismatches++;
            $display("%0t: checksum_good mismatch: expected %0b, got %0b",
                     $time, exp_r.good, checksum_good_o);
          end
        end
      end
    end
  end

  // Receiver: random stall, or a long hold counted here when requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_header_length_checksum_deframer_unit: FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit bad_sum);
    int         n;
    logic [7:0] b;
    logic [7:0] sum;
    send_byte(SyncByte);
    send_byte(ResyncByte);
    if (len > DEPTH) n = DEPTH + 4;
    else if (len == 0) n = 2;
    else n = len;
    sum = 8'd0;
    for (int i = 0; i < n; i++) begin
      if (i == 0) b = 8'(len);
      else b = 8'($urandom_range(255));
      // mostly keep markers out of the payload, but let a few through
      if (i > 0 && (b == SyncByte || b == ResyncByte) && $urandom_range(9) != 0)
        b = b ^ 8'h0F;
      if (len >= 3 && i == len - 2) begin
        b = bad_sum ? 8'(sum + $urandom_range(1, 255)) : sum;
      end else if (i == n - 1 && i > 0 && (b == SyncByte || b == ResyncByte)) begin
        b = 8'h00;
      end
      if (i + 3 <= len) sum = sum + b;
      send_byte(b);
    end
  endtask

  task automatic test_directed();
    // minimal good frame: length 3, command doubles as checksum
    send_byte(SyncByte); send_byte(ResyncByte);
    send_byte(8'h03); send_byte(8'h03); send_byte(8'h00);
    // short lengths
    send_byte(SyncByte); send_byte(ResyncByte); send_byte(8'h01);
    send_byte(SyncByte); send_byte(ResyncByte); send_byte(8'h02); send_byte(8'hFF);
    // stored markers: lone resync byte as command, sync byte as payload
    send_byte(SyncByte); send_byte(ResyncByte);
    send_byte(8'h05); send_byte(ResyncByte); send_byte(SyncByte);
    send_byte(8'h04); send_byte(8'h11);
    // length beyond the buffer, then bad checksum on a small frame
    send_byte(SyncByte); send_byte(ResyncByte); send_byte(8'hC8); send_byte(8'h7E);
    send_frame(4, 1'b1);
  endtask

  task automatic test_full_buffer();
    send_frame(DEPTH, 1'b0);
    repeat (3) send_byte(8'($urandom_range(0, 8'h59)));
    send_frame(DEPTH, 1'b1);
    repeat (2) send_byte(8'hFF);
    send_frame(255, 1'b0);
  endtask

  task automatic test_random(input int idle_pct, input int stall_p, input int n_bytes);
    int target;
    int sel;
    int len;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    target        = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        sel = $urandom_range(99);
        if (sel < 70) len = $urandom_range(3, 16);
        else if (sel < 85) len = $urandom_range(17, DEPTH);
        else if (sel < 92) len = $urandom_range(0, 2);
        else len = $urandom_range(DEPTH + 1, 255);
        send_frame(len, $urandom_range(99) < 25);
      end else if (sel < 87) begin
        // truncated frame: the next header cuts it off
        len = $urandom_range(4, 30);
        send_byte(SyncByte); send_byte(ResyncByte); send_byte(8'(len));
        repeat ($urandom_range(0, len - 3)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_start    = 1'b1;
    repeat (40) send_frame(3, $urandom_range(99) < 25);
  endtask

  initial begin
    wr_pos    = 8'd0;
    hdr_armed = 1'b0;
    frame_len = 8'd0;
    cmd_byte  = 8'd0;
    sum_acc   = 8'd0;
    sum_rcvd  = 8'd0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_buffer();
    test_random(20, 60, 450);
    test_random(60, 20, 450);
    test_backpressure();
    test_random(0, 0, 450);

    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d frame results (%0d good, %0d failed).",
             bytes_sent, frames_seen, good_frames, frames_seen - good_frames);
    $display("Covered short, oversized and full-buffer frames, markers in payload,");
    $display("truncated frames, noise and a %0d-cycle output hold.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb_header_length_checksum_deframer_unit: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_header_length_checksum_deframer_unit: FAIL");
    end
    $finish;
  end

endmodule
